@@ hdl/wcti_pkg.sv @@
// ----------------------------------------------------------------------------
// wcti_pkg
// Shared types, widths and helpers for the wrapped cubic table interpolator.
// ----------------------------------------------------------------------------
package wcti_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_BITS  = 12;
    localparam int POS_BITS    = INDEX_BITS + FRAC_BITS;
    localparam int LEN_BITS    = 13;

    // Horner intermediates stay below 2^27 in magnitude; one spare bit.
    localparam int TW = 29;
    localparam int PW = TW + FRAC_BITS + 1;

    localparam logic [LEN_BITS-1:0] MIN_LENGTH = LEN_BITS'(4);
    localparam int OFFSET_BIAS = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Tap order within one read transaction
    localparam logic [1:0] SLOT_M2 = 2'd0;
    localparam logic [1:0] SLOT_M1 = 2'd1;
    localparam logic [1:0] SLOT_Z  = 2'd2;
    localparam logic [1:0] SLOT_P1 = 2'd3;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam logic [FIFO_PTR_BITS:0] FIFO_FULL = {1'b1, {FIFO_PTR_BITS{1'b0}}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FRAC_BITS-1:0]          mu_t;
    typedef logic signed [TW-1:0]          coef_t;
    typedef logic signed [PW-1:0]          prod_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] slot;
        mu_t        mu;
    } rd_tag_t;

    typedef struct packed {
        logic    clipped;
        sample_t sample;
    } result_t;

    function automatic coef_t sx(input sample_t s);
        sx = {{(TW-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

    function automatic prod_t mul_frac(input coef_t a, input mu_t m);
        prod_t ae;
        prod_t me;
        ae = {{(PW-TW){a[TW-1]}}, a};
        me = {{(PW-FRAC_BITS){1'b0}}, m};
        mul_frac = ae * me;
    endfunction

    // floor((p + half) / 2^FRAC_BITS)
    function automatic coef_t round_frac(input prod_t p);
        prod_t y;
        y = p + {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
        round_frac = y[FRAC_BITS +: TW];
    endfunction

endpackage

@@ hdl/wrapped_cubic_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// wrapped_cubic_table_interpolator
// Sample table with four-point cubic interpolation at a fixed-point position.
// ----------------------------------------------------------------------------
// The table sits in one single-port RAM. A write transaction (tuser = 0)
// makes one memory access; a read transaction (tuser = 1) makes four, one
// per table tap at p-2, p-1, p and p+1, so a new read is taken only once the
// last tap of the one before is issued, and writes are taken at one per cycle
// while fewer than four results are outstanding. The taps feed a pipelined
// Horner evaluator with three multipliers; each result waits in a 4-entry
// output queue. When four results are outstanding the input stalls. All
// table accesses go through the one port in arrival order, so a read always
// sees every earlier write. The table is not cleared at reset: entries read
// before being written return undefined data. table_length may be written
// only while the block is idle; values below 4 act as 4 and values above
// TABLE_DEPTH act as TABLE_DEPTH.
// ----------------------------------------------------------------------------
module wrapped_cubic_table_interpolator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,    // table_length

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // [11:0] write_address, [35:12] write_sample,
                                        // [63:36] position
    input  logic [0:0]  s_tuser,        // [0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [23:0] sample_out
    output logic [0:0]  m_tuser         // [0] clipped
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int LEN_CAP = (TABLE_DEPTH < 8191) ? TABLE_DEPTH : 8191;
    localparam int IDX_W   = wcti_pkg::LEN_BITS + 2;

    // Reduce a wrapped index below TABLE_DEPTH; inputs stay under 256*TABLE_DEPTH
    function automatic logic [wcti_pkg::LEN_BITS-1:0] reduce_idx(
        input logic [wcti_pkg::LEN_BITS-1:0] v
    );
        logic [wcti_pkg::LEN_BITS-1:0] r;
        r = v;
        for (int k = 7; k >= 0; k--) begin
            if (int'(r) >= (TABLE_DEPTH << k)) begin
                r = r - wcti_pkg::LEN_BITS'(TABLE_DEPTH << k);
            end
        end
        reduce_idx = r;
    endfunction

    logic [wcti_pkg::LEN_BITS-1:0] table_length_reg;
    logic [wcti_pkg::LEN_BITS-1:0] len;

    logic                          op_busy_reg;
    logic                          op_read_reg;
    logic [1:0]                    op_cnt_reg;
    logic [wcti_pkg::POS_BITS-1:0] op_pos_reg;
    logic [wcti_pkg::INDEX_BITS-1:0] op_waddr_reg;
    wcti_pkg::sample_t             op_wdata_reg;
    logic                          op_last;

    logic [wcti_pkg::FIFO_PTR_BITS:0] inflight_reg;
    logic                             s_accept;
    logic                             m_accept;

    logic signed [IDX_W-1:0]       idx_raw;
    logic signed [IDX_W-1:0]       len_s;
    logic signed [IDX_W-1:0]       idx_wrap;
    logic [wcti_pkg::LEN_BITS-1:0] idx_tab;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    wcti_pkg::sample_t      ram_rdata;
    wcti_pkg::rd_tag_t      rd_tag_reg;

    logic                   res_valid;
    wcti_pkg::result_t      res;

    wcti_pkg::result_t                fifo_mem_reg [wcti_pkg::FIFO_DEPTH];
    logic [wcti_pkg::FIFO_PTR_BITS-1:0] fifo_wr_reg, fifo_rd_reg;
    logic [wcti_pkg::FIFO_PTR_BITS:0]   fifo_cnt_reg;

    // ---- configuration ------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= wcti_pkg::LEN_BITS'(LEN_CAP);
        end else if (cfg_wr_en) begin
            table_length_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (table_length_reg < wcti_pkg::MIN_LENGTH) begin
            len = wcti_pkg::MIN_LENGTH;
        end else if (int'(table_length_reg) > LEN_CAP) begin
            len = wcti_pkg::LEN_BITS'(LEN_CAP);
        end else begin
            len = table_length_reg;
        end
    end

    // ---- input sequencer: one memory access per cycle ------------------------
    assign op_last  = op_read_reg ? (op_cnt_reg == wcti_pkg::SLOT_P1) : 1'b1;
    assign s_tready = (!op_busy_reg || op_last) && (inflight_reg != wcti_pkg::FIFO_FULL);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_busy_reg <= 1'b0;
            op_read_reg <= 1'b0;
            op_cnt_reg  <= wcti_pkg::SLOT_M2;
        end else if (s_accept) begin
            op_busy_reg <= 1'b1;
            op_read_reg <= (s_tuser[0] == wcti_pkg::CMD_READ);
            op_cnt_reg  <= wcti_pkg::SLOT_M2;
        end else if (op_busy_reg && op_last) begin
            op_busy_reg <= 1'b0;
        end else if (op_busy_reg) begin
            op_cnt_reg  <= op_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_waddr_reg <= s_tdata[11:0];
            op_wdata_reg <= s_tdata[35:12];
            op_pos_reg   <= s_tdata[63:36];
        end
    end

    // ---- tap address: one wrap against the length, then fold into the table -
    always_comb begin
        idx_raw = $signed({3'b000, op_pos_reg[wcti_pkg::POS_BITS-1:wcti_pkg::FRAC_BITS]})
                + $signed({{(IDX_W-2){1'b0}}, op_cnt_reg})
                - IDX_W'(wcti_pkg::OFFSET_BIAS);
        len_s   = $signed({2'b00, len});
        if (idx_raw >= len_s) begin
            idx_wrap = idx_raw - len_s;
        end else if (idx_raw[IDX_W-1]) begin
            idx_wrap = idx_raw + len_s;
        end else begin
            idx_wrap = idx_raw;
        end
        idx_tab = reduce_idx(idx_wrap[wcti_pkg::LEN_BITS-1:0]);
    end

    assign ram_we   = op_busy_reg && !op_read_reg && (int'(op_waddr_reg) < TABLE_DEPTH);
    assign ram_addr = op_read_reg ? AW'(idx_tab) : AW'(op_waddr_reg);

    wcti_ram #(
        .WIDTH (wcti_pkg::SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (op_wdata_reg),
        .rdata (ram_rdata)
    );

    // Tag travels alongside the registered RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg.valid <= 1'b0;
        end else begin
            rd_tag_reg.valid <= op_busy_reg && op_read_reg;
        end
        rd_tag_reg.slot <= op_cnt_reg;
        rd_tag_reg.mu   <= op_pos_reg[wcti_pkg::FRAC_BITS-1:0];
    end

    wcti_cubic u_cubic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_tag    (rd_tag_reg),
        .rd_data   (ram_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---- output queue; credits keep it from overflowing ----------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            fifo_cnt_reg <= '0;
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
        end else begin
            case ({s_accept && (s_tuser[0] == wcti_pkg::CMD_READ), m_accept})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: ;
            endcase
            case ({res_valid, m_accept})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - 1'b1;
                default: ;
            endcase
            if (res_valid) begin
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            end
            if (m_accept) begin
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            fifo_mem_reg[fifo_wr_reg] <= res;
        end
    end

    assign m_tvalid   = (fifo_cnt_reg != '0);
    assign m_tdata    = fifo_mem_reg[fifo_rd_reg].sample;
    assign m_tuser[0] = fifo_mem_reg[fifo_rd_reg].clipped;

endmodule

@@ hdl/wcti_ram.sv @@
// ----------------------------------------------------------------------------
// wcti_ram
// Generic single-port RAM, write-first not guaranteed, registered read.
// ----------------------------------------------------------------------------
module wcti_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hdl/wcti_cubic.sv @@
// ----------------------------------------------------------------------------
// wcti_cubic
// Collects the four taps, forms the cubic coefficients and runs the three
// Horner steps as a fixed-latency pipeline, then saturates.
// ----------------------------------------------------------------------------
module wcti_cubic (
    input  logic               aclk,
    input  logic               aresetn,
    input  wcti_pkg::rd_tag_t  rd_tag,
    input  wcti_pkg::sample_t  rd_data,
    output logic               res_valid,
    output wcti_pkg::result_t  res
);

    wcti_pkg::sample_t sm2_reg, sm1_reg, s0_reg;

    logic              cf_valid_reg;
    wcti_pkg::coef_t   cf_a0_reg, cf_a1_reg, cf_a2_reg;
    wcti_pkg::sample_t cf_a3_reg;
    wcti_pkg::mu_t     cf_mu_reg;

    logic              m1_valid_reg;
    wcti_pkg::prod_t   m1_p_reg;
    wcti_pkg::coef_t   m1_a1_reg, m1_a2_reg;
    wcti_pkg::sample_t m1_a3_reg;
    wcti_pkg::mu_t     m1_mu_reg;

    logic              t1_valid_reg;
    wcti_pkg::coef_t   t1_reg, t1_a2_reg;
    wcti_pkg::sample_t t1_a3_reg;
    wcti_pkg::mu_t     t1_mu_reg;

    logic              m2_valid_reg;
    wcti_pkg::prod_t   m2_p_reg;
    wcti_pkg::coef_t   m2_a2_reg;
    wcti_pkg::sample_t m2_a3_reg;
    wcti_pkg::mu_t     m2_mu_reg;

    logic              t2_valid_reg;
    wcti_pkg::coef_t   t2_reg;
    wcti_pkg::sample_t t2_a3_reg;
    wcti_pkg::mu_t     t2_mu_reg;

    logic              m3_valid_reg;
    wcti_pkg::prod_t   m3_p_reg;
    wcti_pkg::sample_t m3_a3_reg;

    logic              out_valid_reg;
    wcti_pkg::result_t out_reg;

    wcti_pkg::coef_t   a0_next, a1_next, a2_next;
    wcti_pkg::coef_t   t3;
    wcti_pkg::result_t out_next;
    logic              last_tap;

    assign last_tap = rd_tag.valid && (rd_tag.slot == wcti_pkg::SLOT_P1);

    always_comb begin
        a0_next = wcti_pkg::sx(rd_data) - wcti_pkg::sx(s0_reg)
                - wcti_pkg::sx(sm2_reg) + wcti_pkg::sx(sm1_reg);
        a1_next = wcti_pkg::sx(sm2_reg) - wcti_pkg::sx(sm1_reg) - a0_next;
        a2_next = wcti_pkg::sx(s0_reg) - wcti_pkg::sx(sm2_reg);
    end

    // Saturate: out of range when the bits above the sign do not match it
    always_comb begin
        t3 = wcti_pkg::round_frac(m3_p_reg) + wcti_pkg::sx(m3_a3_reg);
        out_next.sample  = t3[wcti_pkg::SAMPLE_BITS-1:0];
        out_next.clipped = 1'b0;
        if (!t3[wcti_pkg::TW-1] && (|t3[wcti_pkg::TW-2:wcti_pkg::SAMPLE_BITS-1])) begin
            out_next.sample  = {1'b0, {(wcti_pkg::SAMPLE_BITS-1){1'b1}}};
            out_next.clipped = 1'b1;
        end else if (t3[wcti_pkg::TW-1]
                     && !(&t3[wcti_pkg::TW-2:wcti_pkg::SAMPLE_BITS-1])) begin
            out_next.sample  = {1'b1, {(wcti_pkg::SAMPLE_BITS-1){1'b0}}};
            out_next.clipped = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cf_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            t1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cf_valid_reg  <= last_tap;
            m1_valid_reg  <= cf_valid_reg;
            t1_valid_reg  <= m1_valid_reg;
            m2_valid_reg  <= t1_valid_reg;
            t2_valid_reg  <= m2_valid_reg;
            m3_valid_reg  <= t2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_tag.valid) begin
            case (rd_tag.slot)
                wcti_pkg::SLOT_M2: sm2_reg <= rd_data;
                wcti_pkg::SLOT_M1: sm1_reg <= rd_data;
                wcti_pkg::SLOT_Z:  s0_reg  <= rd_data;
                default: ;
            endcase
        end

        cf_a0_reg <= a0_next;
        cf_a1_reg <= a1_next;
        cf_a2_reg <= a2_next;
        cf_a3_reg <= sm1_reg;
        cf_mu_reg <= rd_tag.mu;

        m1_p_reg  <= wcti_pkg::mul_frac(cf_a0_reg, cf_mu_reg);
        m1_a1_reg <= cf_a1_reg;
        m1_a2_reg <= cf_a2_reg;
        m1_a3_reg <= cf_a3_reg;
        m1_mu_reg <= cf_mu_reg;

        t1_reg    <= wcti_pkg::round_frac(m1_p_reg) + m1_a1_reg;
        t1_a2_reg <= m1_a2_reg;
        t1_a3_reg <= m1_a3_reg;
        t1_mu_reg <= m1_mu_reg;

        m2_p_reg  <= wcti_pkg::mul_frac(t1_reg, t1_mu_reg);
        m2_a2_reg <= t1_a2_reg;
        m2_a3_reg <= t1_a3_reg;
        m2_mu_reg <= t1_mu_reg;

        t2_reg    <= wcti_pkg::round_frac(m2_p_reg) + m2_a2_reg;
        t2_a3_reg <= m2_a3_reg;
        t2_mu_reg <= m2_mu_reg;

        m3_p_reg  <= wcti_pkg::mul_frac(t2_reg, t2_mu_reg);
        m3_a3_reg <= t2_a3_reg;

        out_reg   <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wrapped cubic table interpolator. A queue of
// table writes, interpolated reads and idle-point length updates feeds a
// bursty stream driver. A shadow copy of the sample table predicts each read
// result, and a stalling result monitor checks them in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_ENTRIES  = 4096;
    localparam int PHASE_ITEMS    = 190;
    localparam int SETTLE_CYCLES  = 32;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [wcti_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [wcti_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;

    // One entry of the stimulus queue: either a stream transaction or a
    // drain point, optionally followed by a table_length update.
    typedef struct packed {
        logic                              is_sync;
        logic                              do_cfg;
        logic [wcti_pkg::LEN_BITS-1:0]     cfg_value;
        logic                              cmd;
        logic [wcti_pkg::INDEX_BITS-1:0]   addr;
        logic [wcti_pkg::SAMPLE_BITS-1:0]  value;
        logic [wcti_pkg::POS_BITS-1:0]     pos;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    wrapped_cubic_table_interpolator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    step_t             pending_steps[$];
    wcti_pkg::result_t expected_results[$];

    // shadow state of the block
    wcti_pkg::sample_t             shadow_samples [TABLE_ENTRIES];
    logic [wcti_pkg::LEN_BITS-1:0] shadow_length = wcti_pkg::LEN_BITS'(4096);

    // generation-side view: which entries hold data, and the length in force
    bit                            gen_written [TABLE_ENTRIES];
    logic [wcti_pkg::LEN_BITS-1:0] gen_length = wcti_pkg::LEN_BITS'(4096);
    int                            step_count = 0;

    bit in_taken = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int settle_count = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int results_seen = 0;
    int errors = 0;
    int quiet_cycles = 0;

    function automatic int effective_length(logic [wcti_pkg::LEN_BITS-1:0] v);
        if (v < wcti_pkg::MIN_LENGTH) return 4;
        if (v > wcti_pkg::LEN_BITS'(TABLE_ENTRIES)) return TABLE_ENTRIES;
        return int'(v);
    endfunction

    // single wrap against the length, then folded into the table
    function automatic int tap_index(int p, int off, int len);
        int idx;
        idx = p + off;
        if (idx >= len) idx -= len;
        else if (idx < 0) idx += len;
        if (idx < 0 || idx >= TABLE_ENTRIES)
            idx = ((idx % TABLE_ENTRIES) + TABLE_ENTRIES) % TABLE_ENTRIES;
        return idx;
    endfunction

    // floor((x + half) / 2^16)
    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> wcti_pkg::FRAC_BITS;
    endfunction

    function automatic wcti_pkg::result_t interpolate(logic [wcti_pkg::POS_BITS-1:0] pos);
        int                len;
        int                p;
        int                k;
        longint            s [4];
        longint            mu;
        longint            a0;
        longint            a1;
        longint            a2;
        longint            a3;
        longint            acc;
        wcti_pkg::result_t r;
        len = effective_length(shadow_length);
        p = int'(pos[wcti_pkg::POS_BITS-1:wcti_pkg::FRAC_BITS]);
        mu = longint'(pos[wcti_pkg::FRAC_BITS-1:0]);
        for (k = 0; k < 4; k++)
            s[k] = shadow_samples[tap_index(p, k - 2, len)];
        // s[0..3] = taps at p-2, p-1, p, p+1
        a0 = s[3] - s[2] - s[0] + s[1];
        a1 = s[0] - s[1] - a0;
        a2 = s[2] - s[0];
        a3 = s[1];
        acc = round_q16(a0 * mu) + a1;
        acc = round_q16(acc * mu) + a2;
        acc = round_q16(acc * mu) + a3;
        r.clipped = 1'b0;
        if (acc > 64'sd8388607) begin
            acc = 64'sd8388607;
            r.clipped = 1'b1;
        end else if (acc < -64'sd8388608) begin
            acc = -64'sd8388608;
            r.clipped = 1'b1;
        end
        r.sample = wcti_pkg::sample_t'(acc);
        return r;
    endfunction

    function automatic logic [wcti_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return wcti_pkg::SAMPLE_BITS'($urandom_range(0, 64))
                      - wcti_pkg::SAMPLE_BITS'(32);
            default: return wcti_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [wcti_pkg::FRAC_BITS-1:0] rand_mu();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            default: return wcti_pkg::FRAC_BITS'($urandom);
        endcase
    endfunction

    task automatic push_write(int addr, logic [wcti_pkg::SAMPLE_BITS-1:0] v);
        step_t st;
        st = '0;
        st.cmd = wcti_pkg::CMD_WRITE;
        st.addr = wcti_pkg::INDEX_BITS'(addr);
        st.value = v;
        st.pos = wcti_pkg::POS_BITS'($urandom);
        pending_steps.push_back(st);
        gen_written[addr] = 1'b1;
        step_count++;
    endtask

    // fills any tap not yet written so no read touches undefined data
    task automatic push_read(int p, logic [wcti_pkg::FRAC_BITS-1:0] mu);
        step_t st;
        int    k;
        int    idx;
        for (k = 0; k < 4; k++) begin
            idx = tap_index(p, k - 2, effective_length(gen_length));
            if (!gen_written[idx]) push_write(idx, rand_sample());
        end
        st = '0;
        st.cmd = wcti_pkg::CMD_READ;
        st.addr = wcti_pkg::INDEX_BITS'($urandom);
        st.value = wcti_pkg::SAMPLE_BITS'($urandom);
        st.pos = {wcti_pkg::INDEX_BITS'(p), mu};
        pending_steps.push_back(st);
        step_count++;
    endtask

    task automatic push_sync(bit do_cfg, logic [wcti_pkg::LEN_BITS-1:0] v);
        step_t st;
        st = '0;
        st.is_sync = 1'b1;
        st.do_cfg = do_cfg;
        st.cfg_value = v;
        pending_steps.push_back(st);
        if (do_cfg) gen_length = v;
    endtask

    // input side: shadow updates on every accepted transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) shadow_length = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                if (s_tuser[0] == wcti_pkg::CMD_WRITE)
                    shadow_samples[s_tdata[11:0]] = s_tdata[35:12];
                else
                    expected_results.push_back(interpolate(s_tdata[63:36]));
            end
        end
    end

    // driver: bursts with random gaps; drain points wait for an idle block
    always @(negedge aclk) begin
        logic  nxt_valid;
        logic  nxt_cfg;
        step_t head;
        nxt_valid = s_tvalid;
        nxt_cfg = 1'b0;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_steps.size() != 0) begin
                head = pending_steps[0];
                if (head.is_sync) begin
                    if (expected_results.size() != 0) begin
                        settle_count = 0;
                    end else if (settle_count < SETTLE_CYCLES) begin
                        settle_count++;
                    end else begin
                        settle_count = 0;
                        void'(pending_steps.pop_front());
                        if (head.do_cfg) begin
                            nxt_cfg = 1'b1;
                            cfg_wr_data <= head.cfg_value;
                        end
                    end
                end else begin
                    void'(pending_steps.pop_front());
                    nxt_valid = 1'b1;
                    s_tdata <= {head.pos, head.value, head.addr};
                    s_tuser <= head.cmd;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
        cfg_wr_en <= nxt_cfg;
    end

    // receiver: changing stall pattern plus one long hold-off under load
    always @(negedge aclk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && results_seen >= 300 && s_tvalid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rdy = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(10, 150);
            end
            rx_mode_left--;
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_tready <= rdy;
    end

    // result monitor
    always @(posedge aclk) begin
        wcti_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction: sample_out %h clipped %b",
                         $time, m_tdata, m_tuser[0]);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.sample) begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want.sample, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.clipped) begin
                    $display("%0t: clipped expected %b actual %b",
                             $time, want.clipped, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("wrapped_cubic_table_interpolator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [wcti_pkg::LEN_BITS-1:0] length_plan [10];
        int ph;
        int len;
        int p;
        int r;
        int budget;
        bit mid_pause_done;

        // reset value first, then out-of-range and extreme lengths
        length_plan = '{13'd4096, 13'd4, 13'd0, 13'd3, 13'd5, 13'd8191,
                        13'd4097, 13'd17, 13'd0, 13'd4096};
        length_plan[8] = wcti_pkg::LEN_BITS'($urandom_range(6, 4095));
        mid_pause_done = 1'b0;

        // directed: full-scale alternating taps, wrap at both ends, extreme mu
        push_write(0, SAMPLE_MAX);
        push_write(1, SAMPLE_MIN);
        push_write(2, SAMPLE_MAX);
        push_write(3, SAMPLE_MIN);
        push_write(4095, SAMPLE_MAX);
        push_write(4094, '0);
        push_read(2, 16'h0000);
        push_read(2, 16'hFFFF);
        push_read(2, 16'h8000);
        push_read(1, 16'h0001);
        push_read(0, 16'h8000);
        push_read(4095, 16'hFFFF);
        push_write(4095, 24'hFFFFFF);
        push_read(4095, 16'h4000);
        push_read(3, 16'h0000);
        push_write(2, SAMPLE_MIN);
        push_read(3, 16'hC000);

        for (ph = 0; ph < 10; ph++) begin
            if (ph > 0) push_sync(1'b1, length_plan[ph]);
            budget = step_count + PHASE_ITEMS;
            while (step_count < budget) begin
                if (ph == 2 && !mid_pause_done && step_count > budget - PHASE_ITEMS / 2) begin
                    push_sync(1'b0, '0);
                    mid_pause_done = 1'b1;
                end
                len = effective_length(gen_length);
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        p = (len - 1 - $urandom_range(0, 1) + $urandom_range(0, 1) * 2) % len;
                    else if (r < 30 && len < TABLE_ENTRIES)
                        p = $urandom_range(len, TABLE_ENTRIES - 1);
                    else
                        p = $urandom_range(0, len - 1);
                    push_read(p, rand_mu());
                end else if (r < 85) begin
                    push_write($urandom_range(0, len - 1), rand_sample());
                end else begin
                    push_write($urandom_range(0, TABLE_ENTRIES - 1), rand_sample());
                end
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_steps.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("wrapped_cubic_table_interpolator: match");
        end else begin
            $display("wrapped_cubic_table_interpolator: mismatch");
        end
        $finish;
    end

endmodule
